// ===== hw/rtl/mrf_pkg.sv =====
package mrf_pkg;

	// Request opcodes as they arrive on the input channel.
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WHDR  = 2'd1;
	localparam logic [1:0] OP_PAY   = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Frame constants.
	localparam logic [7:0]  PREAMBLE = 8'hFF;
	localparam logic [7:0]  FN_READ  = 8'h03;
	localparam logic [7:0]  FN_WRITE = 8'h10;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Command queue between front and back end.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Longest command emits eleven bytes, so a byte index of four bits suffices.
	localparam int IDXW = 4;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_WHDR,
		CMD_PAY
	} mrf_kind_t;

	typedef struct packed {
		mrf_kind_t   kind;
		logic [7:0]  addr;
		logic [15:0] sreg;
		logic [15:0] cnt;
		logic [7:0]  data;
		logic        last;
	} mrf_cmd_t;

	// One byte of the reflected Modbus CRC-16.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/mrf_front.sv =====
module mrf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        device_addr,
	input  logic [15:0]       reg_addr,
	input  logic [15:0]       count,
	input  logic [7:0]        data_byte,
	input  logic              q_full,
	output logic              q_push,
	output mrf_pkg::mrf_cmd_t q_cmd
);
	import mrf_pkg::*;

	logic       pend_q;
	logic [7:0] left_q;
	logic       take;

	assign req_ready = !q_full;
	assign take      = req_valid && req_ready;

	always_comb begin
		q_push      = 1'b0;
		q_cmd.kind  = CMD_READ;
		q_cmd.addr  = device_addr;
		q_cmd.sreg  = reg_addr;
		q_cmd.cnt   = count;
		q_cmd.data  = data_byte;
		q_cmd.last  = (left_q == 8'd1);
		unique case (opcode)
			OP_READ: begin
				q_push     = take;
				q_cmd.kind = CMD_READ;
			end
			OP_WHDR: begin
				q_push     = take;
				q_cmd.kind = CMD_WHDR;
			end
			OP_PAY: begin
				q_push     = take && pend_q;
				q_cmd.kind = CMD_PAY;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Track the open write frame so that stray payload never enters the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			left_q <= 8'd0;
		end else if (take) begin
			case (opcode)
				OP_READ: begin
					pend_q <= 1'b0;
					left_q <= 8'd0;
				end
				OP_WHDR: begin
					pend_q <= (count[7:0] != 8'd0);
					left_q <= count[7:0];
				end
				OP_PAY: begin
					if (pend_q) begin
						left_q <= left_q - 8'd1;
						pend_q <= (left_q != 8'd1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_pend_left: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == (left_q != 8'd0))
		else $error("pending flag disagrees with remaining byte count");

endmodule

// ===== hw/rtl/mrf_queue.sv =====
module mrf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mrf_pkg::mrf_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output mrf_pkg::mrf_cmd_t head_cmd
);
	import mrf_pkg::*;

	mrf_cmd_t         mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;

	assign full       = (cnt_q == QCW'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command popped from an empty queue");

endmodule

// ===== hw/rtl/mrf_back.sv =====
module mrf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  mrf_pkg::mrf_cmd_t head_cmd,
	output logic              pop,
	output logic              tx_valid,
	input  logic              tx_ready,
	output logic [7:0]        tx_byte,
	output logic              frame_end
);
	import mrf_pkg::*;

	logic [IDXW-1:0] idx_q;
	logic [15:0]     crc_q;
	logic [7:0]      tx_byte_q;
	logic            frame_end_q;
	logic            tx_valid_q;

	logic       emit;
	logic [7:0] byte_sel;
	logic       fold_sel;
	logic       end_sel;
	logic       last_sel;

	assign emit = head_valid && (!tx_valid_q || tx_ready);
	assign pop  = emit && last_sel;

	// Byte of the current command at the current index.
	always_comb begin
		byte_sel = PREAMBLE;
		fold_sel = 1'b0;
		end_sel  = 1'b0;
		last_sel = 1'b0;
		unique case (head_cmd.kind) inside
			CMD_READ, CMD_WHDR: begin
				case (idx_q) inside
					4'd0, 4'd1: byte_sel = PREAMBLE;
					4'd2: begin
						byte_sel = head_cmd.addr;
						fold_sel = 1'b1;
					end
					4'd3: begin
						byte_sel = (head_cmd.kind == CMD_READ) ? FN_READ : FN_WRITE;
						fold_sel = 1'b1;
					end
					4'd4: begin
						byte_sel = head_cmd.sreg[15:8];
						fold_sel = 1'b1;
					end
					4'd5: begin
						byte_sel = head_cmd.sreg[7:0];
						fold_sel = 1'b1;
					end
					4'd6: begin
						byte_sel = (head_cmd.kind == CMD_READ) ? head_cmd.cnt[15:8] : 8'h00;
						fold_sel = 1'b1;
					end
					4'd7: begin
						byte_sel = (head_cmd.kind == CMD_READ) ? head_cmd.cnt[7:0] : 8'h00;
						fold_sel = 1'b1;
					end
					4'd8: begin
						if (head_cmd.kind == CMD_READ) begin
							byte_sel = crc_q[7:0];
						end else begin
							byte_sel = head_cmd.cnt[7:0];
							fold_sel = 1'b1;
							last_sel = (head_cmd.cnt[7:0] != 8'd0);
						end
					end
					4'd9: begin
						if (head_cmd.kind == CMD_READ) begin
							byte_sel = crc_q[15:8];
							end_sel  = 1'b1;
							last_sel = 1'b1;
						end else begin
							byte_sel = crc_q[7:0];
						end
					end
					default: begin
						byte_sel = crc_q[15:8];
						end_sel  = 1'b1;
						last_sel = 1'b1;
					end
				endcase
			end
			CMD_PAY: begin
				case (idx_q)
					4'd0: begin
						byte_sel = head_cmd.data;
						fold_sel = 1'b1;
						last_sel = !head_cmd.last;
					end
					4'd1: byte_sel = crc_q[7:0];
					default: begin
						byte_sel = crc_q[15:8];
						end_sel  = 1'b1;
						last_sel = 1'b1;
					end
				endcase
			end
			default: begin
				last_sel = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_byte_q   <= byte_sel;
			frame_end_q <= end_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			crc_q      <= CRC_INIT;
			tx_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				tx_valid_q <= 1'b1;
			end else if (tx_ready) begin
				tx_valid_q <= 1'b0;
			end
			if (emit) begin
				idx_q <= last_sel ? '0 : idx_q + IDXW'(1);
				if (idx_q == '0 && head_cmd.kind != CMD_PAY) begin
					crc_q <= CRC_INIT;
				end else if (fold_sel) begin
					crc_q <= crc_fold(crc_q, byte_sel);
				end else if (end_sel) begin
					crc_q <= CRC_INIT;
				end
			end
		end
	end

	assign tx_valid  = tx_valid_q;
	assign tx_byte   = tx_byte_q;
	assign frame_end = frame_end_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDXW'(10))
		else $error("byte index beyond the longest frame");

	a_crc_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		emit && end_sel |=> crc_q == CRC_INIT)
		else $error("CRC not reinitialized after a closed frame");

endmodule

// ===== hw/rtl/modbus_rtu_request_framer.sv =====
// A request is written into the command queue, and its first byte is then registered into
// the tx byte register, from which it is offered on tx.
// Throughput: one request per cycle enters the four-entry command queue while it has room.
// The back end sends one byte per cycle while tx is ready: a read is 10 bytes, a write
// header 9 (11 with a zero byte count), a payload byte 1 (3 when it closes with the CRC).
// Reset (arst_n low, asynchronous) empties the queue, drops any open write frame and sets
// the CRC to 0xFFFF; the output byte register itself is not reset.
module modbus_rtu_request_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  device_addr,
	input  logic [15:0] reg_addr,
	input  logic [15:0] count,
	input  logic [7:0]  data_byte,
	output logic        tx_valid,
	input  logic        tx_ready,
	output logic [7:0]  tx_byte,
	output logic        frame_end
);
	import mrf_pkg::*;

	// The front end classifies each request. Reads and write headers always become
	// commands; payload bytes become commands only while a write frame is open, and
	// the front end itself counts the announced payload so that the last one is
	// marked before it reaches the queue. Undefined opcodes are simply consumed.
	logic     q_push;
	logic     q_full;
	mrf_cmd_t q_cmd;

	// The queue decouples request acceptance from byte emission, so a stalled
	// byte sink does not stop new requests until the queue fills.
	logic     q_pop;
	logic     head_valid;
	mrf_cmd_t head_cmd;

	mrf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.opcode      (opcode),
		.device_addr (device_addr),
		.reg_addr    (reg_addr),
		.count       (count),
		.data_byte   (data_byte),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	mrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// The back end walks the head command byte by byte, folds each covered byte
	// into the running CRC and appends the CRC, low byte first, when a frame
	// closes. A new read or write header restarts the CRC, which abandons any
	// write frame that was left unfinished.
	mrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.tx_valid   (tx_valid),
		.tx_ready   (tx_ready),
		.tx_byte    (tx_byte),
		.frame_end  (frame_end)
	);

endmodule

// ===== tb/tb.sv =====
module tb;
	import mrf_pkg::*;

	// Run shape. The request target counts every request that is queued for the
	// sender, including ignored opcodes and payload that the framer drops.
	localparam int REQ_TARGET  = 430;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLDOFF_AT  = 150;
	localparam int HOLDOFF_LEN = 300;
	localparam int MAX_SHOWN   = 10;
	localparam int TAIL_CYCLES = 20;

	// One pending request. A drain entry carries no request: it makes the sender
	// wait until every expected byte has come out before it goes on.
	typedef struct {
		bit          drain;
		logic [1:0]  op;
		logic [7:0]  addr;
		logic [15:0] sreg;
		logic [15:0] cnt;
		logic [7:0]  data;
	} req_item_t;

	// One expected byte of the outgoing frame stream.
	typedef struct {
		logic [7:0] b;
		logic       end_flag;
	} tx_beat_t;

	// The receiver switches between several stall styles on its own schedule.
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic [1:0]  opcode = OP_NONE;
	logic [7:0]  device_addr = 8'h00;
	logic [15:0] reg_addr = 16'h0000;
	logic [15:0] count = 16'h0000;
	logic [7:0]  data_byte = 8'h00;
	logic        tx_ready = 1'b0;
	logic        req_ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        frame_end;

	modbus_rtu_request_framer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.opcode      (opcode),
		.device_addr (device_addr),
		.reg_addr    (reg_addr),
		.count       (count),
		.data_byte   (data_byte),
		.tx_valid    (tx_valid),
		.tx_ready    (tx_ready),
		.tx_byte     (tx_byte),
		.frame_end   (frame_end)
	);

	// Requests waiting to be offered, and the frame bytes that accepted requests
	// have promised but the framer has not yet delivered.
	req_item_t req_q[$];
	tx_beat_t  tx_expect_q[$];

	// Shadow of the framer state: running CRC of the open frame, payload bytes
	// still owed to an open write, and whether a write frame is open at all.
	logic [15:0] shadow_crc = CRC_INIT;
	logic [7:0]  shadow_left = 8'h00;
	logic        shadow_open = 1'b0;

	int       err_count = 0;
	int       rx_count = 0;
	int       cycle_count = 0;
	int       req_count = 0;
	logic     req_fire = 1'b0;
	int       gap_left = 0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int       rx_mode_left = 0;
	int       holdoff_left = 0;
	bit       holdoff_done = 1'b0;
	logic [7:0] rx_pat = 8'b1011_0010;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] rnd_b();
		return 8'($urandom());
	endfunction

	function automatic logic [15:0] rnd_w();
		return 16'($urandom());
	endfunction

	// Modbus CRC-16, shifted in one data bit at a time (reflected, poly 0xA001).
	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic expect_byte(input logic [7:0] b, input logic end_flag);
		tx_beat_t t;
		t.b = b;
		t.end_flag = end_flag;
		tx_expect_q.push_back(t);
	endtask

	// Frame bytes between the preamble and the CRC are covered by the CRC.
	task automatic expect_crc_byte(input logic [7:0] b);
		shadow_crc = crc_next(shadow_crc, b);
		expect_byte(b, 1'b0);
	endtask

	// Closing a frame sends the CRC low byte first, marks the high byte as the
	// frame end and puts the framer back into its idle state.
	task automatic expect_close();
		expect_byte(shadow_crc[7:0], 1'b0);
		expect_byte(shadow_crc[15:8], 1'b1);
		shadow_crc = CRC_INIT;
		shadow_open = 1'b0;
		shadow_left = 8'h00;
	endtask

	// Works out the bytes that one accepted request makes the framer send.
	task automatic predict_request(input req_item_t r);
		case (r.op) inside
			OP_READ, OP_WHDR: begin
				// Any new frame abandons a write that is still waiting for payload.
				shadow_crc = CRC_INIT;
				shadow_open = 1'b0;
				shadow_left = 8'h00;
				expect_byte(PREAMBLE, 1'b0);
				expect_byte(PREAMBLE, 1'b0);
				expect_crc_byte(r.addr);
				expect_crc_byte((r.op == OP_READ) ? FN_READ : FN_WRITE);
				expect_crc_byte(r.sreg[15:8]);
				expect_crc_byte(r.sreg[7:0]);
				if (r.op == OP_READ) begin
					expect_crc_byte(r.cnt[15:8]);
					expect_crc_byte(r.cnt[7:0]);
					expect_close();
				end else begin
					// Only the low byte of count is the payload length.
					expect_crc_byte(8'h00);
					expect_crc_byte(8'h00);
					expect_crc_byte(r.cnt[7:0]);
					if (r.cnt[7:0] == 8'h00) begin
						expect_close();
					end else begin
						shadow_left = r.cnt[7:0];
						shadow_open = 1'b1;
					end
				end
			end
			OP_PAY: begin
				// Payload with no open write is dropped silently.
				if (shadow_open) begin
					expect_crc_byte(r.data);
					shadow_left = shadow_left - 8'd1;
					if (shadow_left == 8'h00) begin
						expect_close();
					end
				end
			end
			default: begin
				// The undefined opcode neither sends anything nor touches state.
			end
		endcase
	endtask

	task automatic push_req(input logic [1:0] op, input logic [7:0] addr,
			input logic [15:0] sreg, input logic [15:0] cnt, input logic [7:0] data);
		req_item_t r;
		r.drain = 1'b0;
		r.op = op;
		r.addr = addr;
		r.sreg = sreg;
		r.cnt = cnt;
		r.data = data;
		req_q.push_back(r);
		req_count++;
	endtask

	task automatic push_drain();
		req_item_t r;
		r.drain = 1'b1;
		r.op = OP_NONE;
		r.addr = 8'h00;
		r.sreg = 16'h0000;
		r.cnt = 16'h0000;
		r.data = 8'h00;
		req_q.push_back(r);
	endtask

	// Request sender. It works in bursts separated by random gaps, changes the
	// payload only at the falling edge, and holds valid and payload steady until
	// the request is taken. The acceptance seen at the last rising edge comes in
	// through req_fire, so valid gets exactly one update per step.
	always @(negedge clk) begin : drive
		req_item_t nxt;
		logic      nv;
		bit        load;
		load = 1'b0;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			nv = req_valid && !req_fire;
			if (!nv) begin
				if (req_q.size() > 0 && req_q[0].drain) begin
					// Pause until the framer has delivered everything promised so far.
					if (tx_expect_q.size() == 0) begin
						req_q.delete(0);
					end
				end else if (gap_left > 0) begin
					gap_left--;
				end else if (req_q.size() > 0) begin
					nxt = req_q.pop_front();
					load = 1'b1;
					nv = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			req_valid <= nv;
			if (load) begin
				opcode <= nxt.op;
				device_addr <= nxt.addr;
				reg_addr <= nxt.sreg;
				count <= nxt.cnt;
				data_byte <= nxt.data;
			end
		end
	end

	// Byte receiver. Its stall style changes on a random schedule. Once enough
	// bytes have come out, it refuses everything for a long stretch so that the
	// command queue inside the framer fills and request acceptance stops.
	always @(negedge clk) begin : recv
		logic rdy;
		if (!arst_n) begin
			tx_ready <= 1'b0;
		end else begin
			if (!holdoff_done && rx_count >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_LEN;
			end
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(16, 96);
			end else begin
				rx_mode_left--;
			end
			rx_pat = {rx_pat[6:0], rx_pat[7]};
			case (rx_mode)
				RX_ALWAYS: rdy = 1'b1;
				RX_COIN:   rdy = 1'($urandom_range(0, 1));
				RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
				default:   rdy = rx_pat[0];
			endcase
			if (holdoff_left > 0) begin
				holdoff_left--;
				rdy = 1'b0;
			end
			tx_ready <= rdy;
		end
	end

	// Rising-edge observer: checks each delivered byte against the oldest
	// expectation, and feeds every accepted request to the shadow predictor.
	always @(posedge clk) begin : observe
		tx_beat_t  want;
		req_item_t got;
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			if (tx_valid && tx_ready) begin
				rx_count++;
				if (tx_expect_q.size() == 0) begin
					if (err_count < MAX_SHOWN) begin
						$display("unexpected byte %02h end %0b at result %0d",
							tx_byte, frame_end, rx_count);
					end
					err_count++;
				end else begin
					want = tx_expect_q.pop_front();
					if (tx_byte !== want.b || frame_end !== want.end_flag) begin
						if (err_count < MAX_SHOWN) begin
							$display("result %0d: expected byte %02h end %0b",
								rx_count, want.b, want.end_flag,
								", got byte %02h end %0b", tx_byte, frame_end);
						end
						err_count++;
					end
				end
			end
			req_fire <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				got.drain = 1'b0;
				got.op = opcode;
				got.addr = device_addr;
				got.sreg = reg_addr;
				got.cnt = count;
				got.data = data_byte;
				predict_request(got);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : main
		int n;
		int pick;
		int sel;

		// Directed requests: field extremes, both frame kinds, zero-length
		// writes, stray payload, the undefined opcode, and frames abandoned by
		// a new request while a write still waits for payload.
		push_req(OP_READ, 8'h00, 16'h0000, 16'h0000, 8'h00);
		push_req(OP_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		push_req(OP_WHDR, 8'h5A, 16'h1234, 16'h0000, rnd_b());
		push_req(OP_WHDR, 8'hFF, 16'hFFFF, 16'hFF00, rnd_b());
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'h77);
		push_req(OP_NONE, rnd_b(), rnd_w(), rnd_w(), rnd_b());
		push_req(OP_WHDR, 8'h01, 16'h0000, 16'h0002, rnd_b());
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'h00);
		push_req(OP_NONE, rnd_b(), rnd_w(), rnd_w(), rnd_b());
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'hFF);
		push_req(OP_WHDR, 8'h11, 16'hABCD, 16'h0003, rnd_b());
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'hA5);
		push_req(OP_READ, 8'h22, 16'h0100, 16'h007D, rnd_b());
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'h3C);
		push_req(OP_WHDR, 8'h33, 16'h8000, 16'h0002, rnd_b());
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'h11);
		push_req(OP_WHDR, 8'h44, 16'h00FF, 16'h8001, rnd_b());
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'h80);
		push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), 8'h01);
		push_drain();

		// Random part: mostly complete write frames with random payload, reads,
		// some frames cut short, stray payload, undefined opcodes, and now and
		// then a pause until the framer has caught up.
		while (req_count < REQ_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				push_req(OP_READ, rnd_b(), rnd_w(), rnd_w(), rnd_b());
			end else if (pick < 78) begin
				sel = $urandom_range(0, 99);
				if (sel < 3) begin
					n = 0;
				end else if (sel < 70) begin
					n = $urandom_range(1, 6);
				end else if (sel < 92) begin
					n = $urandom_range(7, 24);
				end else begin
					n = $urandom_range(25, 64);
				end
				push_req(OP_WHDR, rnd_b(), rnd_w(), {rnd_b(), 8'(n)}, rnd_b());
				for (int i = 0; i < n; i++) begin
					sel = $urandom_range(0, 99);
					if (sel < 3) begin
						break;
					end
					if (sel < 8) begin
						push_req(OP_NONE, rnd_b(), rnd_w(), rnd_w(), rnd_b());
					end
					push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), rnd_b());
				end
			end else if (pick < 88) begin
				push_req(OP_PAY, rnd_b(), rnd_w(), rnd_w(), rnd_b());
			end else if (pick < 95) begin
				push_req(OP_NONE, rnd_b(), rnd_w(), rnd_w(), rnd_b());
			end else begin
				push_drain();
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be taken, then for every promised byte,
		// then a short tail to catch anything extra the framer might send.
		while (req_q.size() > 0 || req_valid) begin
			@(posedge clk);
		end
		while (tx_expect_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0 && tx_expect_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
